// ===== hw/rtl/tbq_pkg.sv =====
// Shared types and constants for the transmit buffer pool and descriptor queue.
// No dependencies; imported by every other file of the block.
package tbq_pkg;

    localparam int POOL_SIZE   = 8;
    localparam int QUEUE_DEPTH = 8;

    // Field widths fixed by the request and result formats
    localparam int KIND_W = 3;
    localparam int BUF_W  = 3;
    localparam int LEN_W  = 16;
    localparam int FREE_W = 8;
    localparam int QCNT_W = 4;
    localparam int DROP_W = 32;

    // Internal fill count holds 0..QUEUE_DEPTH
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_ACQUIRE   = 3'd0,
        KIND_RELEASE   = 3'd1,
        KIND_ENQUEUE   = 3'd2,
        KIND_DONE      = 3'd3,
        KIND_NOTE_DROP = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_START,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [BUF_W-1:0] buf_idx;
        logic [LEN_W-1:0] len;
    } desc_t;

    // Shift-queue control broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/tbq_cmd_if.sv =====
// Request channel: valid/ready handshake with the request fields.
// Depends on tbq_pkg for field widths.
interface tbq_cmd_if
    import tbq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BUF_W-1:0]  msg_buf;
    logic [LEN_W-1:0]  length;
    logic              start_refused;

    modport source (output valid, kind, msg_buf, length, start_refused, input ready);
    modport sink   (input valid, kind, msg_buf, length, start_refused, output ready);
endinterface

// ===== hw/rtl/tbq_rsp_if.sv =====
// Result channel: valid/ready handshake with the result fields.
// Depends on tbq_pkg for field widths.
interface tbq_rsp_if
    import tbq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [BUF_W-1:0]  granted_index;
    logic              start_valid;
    logic [BUF_W-1:0]  start_buffer;
    logic [LEN_W-1:0]  start_length;
    logic [FREE_W-1:0] free_bitmap;
    logic [QCNT_W-1:0] queued_count;
    logic              engine_busy;
    logic [DROP_W-1:0] dropped_total;

    modport source (output valid, ok, granted_index, start_valid, start_buffer,
                    start_length, free_bitmap, queued_count, engine_busy,
                    dropped_total, input ready);
    modport sink   (input valid, ok, granted_index, start_valid, start_buffer,
                    start_length, free_bitmap, queued_count, engine_busy,
                    dropped_total, output ready);
endinterface

// ===== hw/rtl/tbq_cell.sv =====
// One slot of the descriptor shift queue. Slot 0 is the head.
// Depends on tbq_pkg (desc_t, cell_ctrl_t).
module tbq_cell
    import tbq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       prev_valid,  // neighbor toward the head holds data
    input  logic       next_valid,  // neighbor toward the tail
    input  desc_t      next_desc,
    input  desc_t      push_desc,
    output logic       valid,
    output desc_t      desc
);

    logic  valid_reg, valid_next;
    desc_t desc_reg, desc_next;

    // Pop shifts everything one slot toward the head; push fills the first empty slot
    always_comb
    begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        if (ctrl.pop)
        begin
            valid_next = next_valid;
            desc_next  = next_desc;
        end
        else if (ctrl.push && prev_valid && !valid_reg)
        begin
            valid_next = 1'b1;
            desc_next  = push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    assign valid = valid_reg;
    assign desc  = desc_reg;

endmodule

// ===== hw/rtl/tx_buffer_pool_dma_queue_top.sv =====
// Top level: buffer pool bitmap, descriptor shift queue of tbq_cell slots, engine control.
// Depends on tbq_pkg, tbq_cmd_if, tbq_rsp_if and tbq_cell.

// Transmit buffer manager. One request is handled at a time. A request is taken
// when the block is idle; it then passes through an executing state, possibly the
// start sequencer state, and a finishing state that writes the result register.
// Only an accepted enqueue or a done with the engine busy enters the start
// sequencer, which pops the head slot if the engine is idle. With start_refused
// set and the engine idle, every waiting descriptor is popped and dropped one
// per cycle. A stalled result register holds the block in the finishing state.
// The result register lets the next request be taken while a result waits.
module tx_buffer_pool_dma_queue_top
    import tbq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    tbq_cmd_if.sink  cmd,
    tbq_rsp_if.source result
);

    state_t state_reg, state_next;

    // Latched request
    logic [KIND_W-1:0] kind_reg;
    logic [BUF_W-1:0]  idx_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              refused_reg;

    // Block state
    logic [POOL_SIZE-1:0]    free_reg, free_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic [BUF_W-1:0]        active_reg, active_next;
    logic [DROP_W-1:0]       drop_reg, drop_next;

    // Per-request result pieces gathered before the result register
    logic             ok_reg, ok_next;
    logic [BUF_W-1:0] grant_reg, grant_next;
    logic             sv_reg, sv_next;
    logic [BUF_W-1:0] sbuf_reg, sbuf_next;
    logic [LEN_W-1:0] slen_reg, slen_next;

    // Result register
    logic              rv_reg, rv_next;
    logic              r_ok_reg;
    logic [BUF_W-1:0]  r_grant_reg;
    logic              r_sv_reg;
    logic [BUF_W-1:0]  r_sbuf_reg;
    logic [LEN_W-1:0]  r_slen_reg;
    logic [FREE_W-1:0] r_free_reg;
    logic [QCNT_W-1:0] r_qcnt_reg;
    logic              r_busy_reg;
    logic [DROP_W-1:0] r_drop_reg;
    logic              load_result;

    // Queue cells
    cell_ctrl_t ctrl;
    desc_t      push_desc;
    logic       cell_valid [QUEUE_DEPTH];
    desc_t      cell_desc  [QUEUE_DEPTH];

    logic             grant_found;
    logic [BUF_W-1:0] grant_idx;

    assign push_desc.buf_idx = idx_reg;
    assign push_desc.len     = len_reg;

    // Chain of queue slots
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic  prev_v;
        logic  next_v;
        desc_t next_d;
        if (i == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_mid
            assign prev_v = cell_valid[i-1];
        end
        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_v = 1'b0;
            assign next_d = '0;
        end
        else
        begin : g_body
            assign next_v = cell_valid[i+1];
            assign next_d = cell_desc[i+1];
        end
        tbq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_desc  (next_d),
            .push_desc  (push_desc),
            .valid      (cell_valid[i]),
            .desc       (cell_desc[i])
        );
    end

    // Lowest free buffer
    always_comb
    begin
        grant_found = 1'b0;
        grant_idx   = '0;
        for (int b = POOL_SIZE - 1; b >= 0; b--)
        begin
            if (free_reg[b])
            begin
                grant_found = 1'b1;
                grant_idx   = BUF_W'(b);
            end
        end
    end

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign load_result = (state_reg == ST_FIN) && (!rv_reg || result.ready);

    // Sequencer: next state and block state updates
    always_comb
    begin
        state_next  = state_reg;
        free_next   = free_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        active_next = active_reg;
        drop_next   = drop_reg;
        ok_next     = ok_reg;
        grant_next  = grant_reg;
        sv_next     = sv_reg;
        sbuf_next   = sbuf_reg;
        slen_next   = slen_reg;
        ctrl.push   = 1'b0;
        ctrl.pop    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                ok_next    = 1'b1;
                grant_next = '0;
                sv_next    = 1'b0;
                sbuf_next  = '0;
                slen_next  = '0;
                state_next = ST_FIN;
                unique case (kind_reg)
                    KIND_ACQUIRE:
                    begin
                        ok_next = grant_found;
                        if (grant_found)
                        begin
                            grant_next = grant_idx;
                            for (int b = 0; b < POOL_SIZE; b++)
                                if (grant_idx == BUF_W'(b))
                                    free_next[b] = 1'b0;
                        end
                    end
                    KIND_RELEASE:
                    begin
                        for (int b = 0; b < POOL_SIZE; b++)
                            if (idx_reg == BUF_W'(b))
                                free_next[b] = 1'b1;
                    end
                    KIND_ENQUEUE:
                    begin
                        if (cnt_reg == CNT_W'(QUEUE_DEPTH))
                            ok_next = 1'b0;
                        else
                        begin
                            ctrl.push  = 1'b1;
                            cnt_next   = cnt_reg + CNT_W'(1);
                            state_next = ST_START;
                        end
                    end
                    KIND_DONE:
                    begin
                        if (busy_reg)
                        begin
                            for (int b = 0; b < POOL_SIZE; b++)
                                if (active_reg == BUF_W'(b))
                                    free_next[b] = 1'b1;
                            busy_next  = 1'b0;
                            state_next = ST_START;
                        end
                    end
                    KIND_NOTE_DROP:
                    begin
                        drop_next = drop_reg + DROP_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_START:
            begin
                // One pop per cycle while idle and descriptors wait
                if (!busy_reg && cnt_reg != '0)
                begin
                    ctrl.pop    = 1'b1;
                    cnt_next    = cnt_reg - CNT_W'(1);
                    active_next = cell_desc[0].buf_idx;
                    if (!refused_reg)
                    begin
                        busy_next  = 1'b1;
                        sv_next    = 1'b1;
                        sbuf_next  = cell_desc[0].buf_idx;
                        slen_next  = cell_desc[0].len;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        for (int b = 0; b < POOL_SIZE; b++)
                            if (cell_desc[0].buf_idx == BUF_W'(b))
                                free_next[b] = 1'b1;
                        drop_next = drop_reg + DROP_W'(1);
                    end
                end
                else
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load_result)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register valid
    always_comb
    begin
        rv_next = rv_reg;
        if (load_result)
            rv_next = 1'b1;
        else if (result.ready)
            rv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            free_reg   <= '1;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            active_reg <= '0;
            drop_reg   <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            free_reg   <= free_next;
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            active_reg <= active_next;
            drop_reg   <= drop_next;
            rv_reg     <= rv_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            kind_reg    <= cmd.kind;
            idx_reg     <= cmd.msg_buf;
            len_reg     <= cmd.length;
            refused_reg <= cmd.start_refused;
        end
        ok_reg    <= ok_next;
        grant_reg <= grant_next;
        sv_reg    <= sv_next;
        sbuf_reg  <= sbuf_next;
        slen_reg  <= slen_next;
        if (load_result)
        begin
            r_ok_reg    <= ok_reg;
            r_grant_reg <= grant_reg;
            r_sv_reg    <= sv_reg;
            r_sbuf_reg  <= sbuf_reg;
            r_slen_reg  <= slen_reg;
            r_free_reg  <= FREE_W'(free_reg);
            r_qcnt_reg  <= QCNT_W'(cnt_reg);
            r_busy_reg  <= busy_reg;
            r_drop_reg  <= drop_reg;
        end
    end

    assign result.valid         = rv_reg;
    assign result.ok            = r_ok_reg;
    assign result.granted_index = r_grant_reg;
    assign result.start_valid   = r_sv_reg;
    assign result.start_buffer  = r_sbuf_reg;
    assign result.start_length  = r_slen_reg;
    assign result.free_bitmap   = r_free_reg;
    assign result.queued_count  = r_qcnt_reg;
    assign result.engine_busy   = r_busy_reg;
    assign result.dropped_total = r_drop_reg;

endmodule

// ===== hw/rtl/tbq_checker.sv =====
// Port-level checks on the result channel of the buffer manager, and the bind.
// Depends on tbq_pkg and tx_buffer_pool_dma_queue_top.
module tbq_checker
    import tbq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              ok,
    input logic [BUF_W-1:0]  granted_index,
    input logic              start_valid,
    input logic [BUF_W-1:0]  start_buffer,
    input logic [LEN_W-1:0]  start_length,
    input logic [QCNT_W-1:0] queued_count,
    input logic              engine_busy
);

    // A waiting result holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(start_length))
        else $error("result dropped or changed while stalled");

    // Idle engine leaves no descriptor waiting
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !engine_busy |-> queued_count == '0)
        else $error("descriptors left waiting with engine idle");

    // A started transfer leaves the engine busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && start_valid |-> engine_busy)
        else $error("start reported with engine idle");

    // No start means zero descriptor fields
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !start_valid |-> start_buffer == '0 && start_length == '0)
        else $error("start descriptor without a start");

    // A failed request grants nothing
    a_fail_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !ok |-> granted_index == '0)
        else $error("grant index on a failed request");

endmodule

bind tx_buffer_pool_dma_queue_top tbq_checker u_tbq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (result.valid),
    .rsp_ready     (result.ready),
    .ok            (result.ok),
    .granted_index (result.granted_index),
    .start_valid   (result.start_valid),
    .start_buffer  (result.start_buffer),
    .start_length  (result.start_length),
    .queued_count  (result.queued_count),
    .engine_busy   (result.engine_busy)
);

// ===== tb/testbench.sv =====
// Self-checking bench for the transmit buffer pool and descriptor queue.
// Drives tbq_cmd_if requests and checks every tbq_rsp_if result against a predictor.
// Depends on tbq_pkg, tbq_cmd_if, tbq_rsp_if and tx_buffer_pool_dma_queue_top.
module testbench;
    import tbq_pkg::*;

    localparam int RUN_LIMIT = 300000;
    localparam int MAX_PRINTS = 100;
    localparam int PHASE_REQUESTS = 170;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BUF_W-1:0]  msg_buf;
        logic [LEN_W-1:0]  length;
        logic              start_refused;
    } pool_req_t;

    typedef struct {
        logic              ok;
        logic [BUF_W-1:0]  granted_index;
        logic              start_valid;
        logic [BUF_W-1:0]  start_buffer;
        logic [LEN_W-1:0]  start_length;
        logic [FREE_W-1:0] free_bitmap;
        logic [QCNT_W-1:0] queued_count;
        logic              engine_busy;
        logic [DROP_W-1:0] dropped_total;
    } pool_status_t;

    logic clk = 1'b0;
    logic rst_n;

    tbq_cmd_if cmd_ch();
    tbq_rsp_if rsp_ch();

    tx_buffer_pool_dma_queue_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (rsp_ch)
    );

    always #6 clk = ~clk;

    // Requests waiting to be offered, and status words still owed by the block
    pool_req_t    request_q[$];
    pool_status_t status_due_q[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int requests_taken = 0;
    int results_checked = 0;
    int starts_seen = 0;
    int rejects_seen = 0;

    // Predictor state: free mask, descriptor ring, engine and drop counter
    logic [FREE_W-1:0] pool_free;
    desc_t             desc_mem[QUEUE_DEPTH];
    logic [PTR_W-1:0]  desc_head;
    logic [PTR_W-1:0]  desc_tail;
    int                desc_fill;
    logic              engine_on;
    logic [BUF_W-1:0]  active_buf;
    logic [DROP_W-1:0] drop_total;

    function automatic void release_buffer(input logic [BUF_W-1:0] idx);
        if (idx < POOL_SIZE)
        begin
            pool_free[idx] = 1'b1;
        end
    endfunction

    // Pop descriptors while idle; a refused start frees the buffer and counts a drop
    function automatic void launch_pending(input logic refused, inout pool_status_t st);
        desc_t d;
        while (!engine_on && desc_fill > 0)
        begin
            d = desc_mem[desc_head];
            desc_head = desc_head + 1'b1;
            desc_fill--;
            active_buf = d.buf_idx;
            if (!refused)
            begin
                engine_on = 1'b1;
                st.start_valid = 1'b1;
                st.start_buffer = d.buf_idx;
                st.start_length = d.len;
            end
            else
            begin
                release_buffer(active_buf);
                drop_total++;
            end
        end
    endfunction

    function automatic pool_status_t apply_request(pool_req_t r);
        pool_status_t st;
        bit found;
        st = '{default: '0};
        st.ok = 1'b1;
        found = 1'b0;
        case (r.kind)
            KIND_ACQUIRE:
            begin
                for (int b = 0; b < POOL_SIZE; b++)
                begin
                    if (!found && pool_free[b])
                    begin
                        pool_free[b] = 1'b0;
                        st.granted_index = b[BUF_W-1:0];
                        found = 1'b1;
                    end
                end
                st.ok = found;
            end
            KIND_RELEASE:
                release_buffer(r.msg_buf);
            KIND_ENQUEUE:
            begin
                if (desc_fill >= QUEUE_DEPTH)
                begin
                    st.ok = 1'b0;
                end
                else
                begin
                    desc_mem[desc_tail] = '{buf_idx: r.msg_buf, len: r.length};
                    desc_tail = desc_tail + 1'b1;
                    desc_fill++;
                    launch_pending(r.start_refused, st);
                end
            end
            KIND_DONE:
            begin
                if (engine_on)
                begin
                    release_buffer(active_buf);
                    engine_on = 1'b0;
                    launch_pending(r.start_refused, st);
                end
            end
            KIND_NOTE_DROP:
                drop_total++;
            default:
                ;
        endcase
        st.free_bitmap = pool_free;
        st.queued_count = desc_fill[QCNT_W-1:0];
        st.engine_busy = engine_on;
        st.dropped_total = drop_total;
        if (st.start_valid)
            starts_seen++;
        if (!st.ok)
            rejects_seen++;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
        begin
            $display("[%0d] MISMATCH %s: got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic queue_req(input logic [KIND_W-1:0] k, input logic [BUF_W-1:0] b,
                             input logic [LEN_W-1:0] len, input logic refused);
        request_q.push_back('{kind: k, msg_buf: b, length: len,
                              start_refused: refused});
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || status_due_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Request driver: hold an offered request until taken, predict on acceptance
    always @(posedge clk)
    begin : request_driver
        pool_req_t next_req;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                status_due_q.push_back(apply_request(request_q.pop_front()));
                requests_taken++;
            end
            if (cmd_ch.valid && !cmd_ch.ready)
            begin
                // keep offering the same request
            end
            else if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                next_req = request_q[0];
                cmd_ch.valid <= 1'b1;
                cmd_ch.kind <= next_req.kind;
                cmd_ch.msg_buf <= next_req.msg_buf;
                cmd_ch.length <= next_req.length;
                cmd_ch.start_refused <= next_req.start_refused;
            end
            else
            begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each accepted status with the oldest prediction
    always @(posedge clk)
    begin : status_monitor
        pool_status_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (status_due_q.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding", 0, 0);
                end
                else
                begin
                    want = status_due_q.pop_front();
                    check_field("ok", 32'(rsp_ch.ok), 32'(want.ok));
                    check_field("granted_index", 32'(rsp_ch.granted_index),
                                32'(want.granted_index));
                    check_field("start_valid", 32'(rsp_ch.start_valid),
                                32'(want.start_valid));
                    check_field("start_buffer", 32'(rsp_ch.start_buffer),
                                32'(want.start_buffer));
                    check_field("start_length", 32'(rsp_ch.start_length),
                                32'(want.start_length));
                    check_field("free_bitmap", 32'(rsp_ch.free_bitmap),
                                32'(want.free_bitmap));
                    check_field("queued_count", 32'(rsp_ch.queued_count),
                                32'(want.queued_count));
                    check_field("engine_busy", 32'(rsp_ch.engine_busy),
                                32'(want.engine_busy));
                    check_field("dropped_total", rsp_ch.dropped_total, want.dropped_total);
                    results_checked++;
                end
            end
            rsp_ch.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Long receiver hold-off, counted down once armed
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int pick;
        logic [LEN_W-1:0] len;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind = KIND_ACQUIRE;
        cmd_ch.msg_buf = '0;
        cmd_ch.length = '0;
        cmd_ch.start_refused = 1'b0;
        rsp_ch.ready = 1'b0;
        pool_free = '1;
        foreach (desc_mem[i])
            desc_mem[i] = '0;
        desc_head = '0;
        desc_tail = '0;
        desc_fill = 0;
        engine_on = 1'b0;
        active_buf = '0;
        drop_total = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: exhaust the pool, releases, start, refused drain, idle done
        repeat (POOL_SIZE + 1) queue_req(KIND_ACQUIRE, '0, '0, 1'b0);
        queue_req(KIND_RELEASE, 3'd7, '0, 1'b0);
        queue_req(KIND_RELEASE, 3'd7, '0, 1'b0);     // already free
        queue_req(KIND_RELEASE, 3'd0, 16'hFFFF, 1'b1);
        queue_req(KIND_ENQUEUE, 3'd3, 16'hFFFF, 1'b0); // starts at once
        queue_req(KIND_ENQUEUE, 3'd5, 16'h0000, 1'b0); // waits behind busy engine
        queue_req(KIND_ENQUEUE, 3'd1, 16'h1234, 1'b1); // refused, but engine busy
        queue_req(KIND_DONE, '0, '0, 1'b1);            // drops both waiting
        queue_req(KIND_DONE, '0, '0, 1'b0);            // done while idle
        queue_req(KIND_NOTE_DROP, '0, '0, 1'b0);
        queue_req(KIND_SPARE_LO, 3'd6, 16'hAAAA, 1'b1);
        queue_req(KIND_SPARE_HI, 3'd2, 16'h5555, 1'b0);
        queue_req(KIND_ENQUEUE, 3'd6, 16'h8001, 1'b1); // refused while idle
        queue_req(KIND_ACQUIRE, '0, '0, 1'b0);
        wait_drained();

        // Back-pressure: receiver holds off while enqueues past full queue depth are offered
        rx_hold_left = 300;
        for (int i = 0; i < QUEUE_DEPTH + 2; i++)
            queue_req(KIND_ENQUEUE, i[BUF_W-1:0], LEN_W'($urandom), 1'b0);
        queue_req(KIND_DONE, '0, '0, 1'b0);
        queue_req(KIND_DONE, '0, '0, 1'b1);
        wait_drained();

        // Random phases with different idling on each side
        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct = (ph == 1) ? 69 : (ph == 3) ? 34 : 0;
            rx_stall_pct = (ph == 2) ? 69 : (ph == 3) ? 34 : 0;
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                pick = $urandom_range(99);
                len = LEN_W'($urandom);
                if ($urandom_range(9) == 0)
                    len = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                if (pick < 22)
                    queue_req(KIND_ACQUIRE, BUF_W'($urandom), len, $urandom_range(99) < 15);
                else if (pick < 34)
                    queue_req(KIND_RELEASE, BUF_W'($urandom), len, $urandom_range(99) < 15);
                else if (pick < 66)
                    queue_req(KIND_ENQUEUE, BUF_W'($urandom), len, $urandom_range(99) < 15);
                else if (pick < 88)
                    queue_req(KIND_DONE, BUF_W'($urandom), len, $urandom_range(99) < 15);
                else if (pick < 94)
                    queue_req(KIND_NOTE_DROP, BUF_W'($urandom), len, 1'($urandom_range(1)));
                else
                    queue_req(KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)),
                              BUF_W'($urandom), len, 1'($urandom_range(1)));
            end
            wait_drained();
        end

        // Let any stray result surface before deciding
        repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);
        $display("Ran %0d requests, checked %0d results over four idling phases and a hold-off.",
                 requests_taken, results_checked);
        $display("Predicted %0d transfer starts, %0d refusals, final drop count %0d.",
                 starts_seen, rejects_seen, drop_total);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tbq_pkg.sv
hw/rtl/tbq_cmd_if.sv
hw/rtl/tbq_rsp_if.sv
hw/rtl/tbq_cell.sv
hw/rtl/tx_buffer_pool_dma_queue_top.sv
hw/rtl/tbq_checker.sv
tb/testbench.sv
